// File: src/kcub_pkg.sv
// Shared types and constants for the k-core upper bound update block.
`default_nettype none

package kcub_pkg;

    localparam int MAX_CORE_DEF = 512;

    localparam int BOUND_W   = 10;
    localparam int COUNT_W   = 16;
    localparam int DEPOSIT_W = 12;
    localparam int HCNT_W    = 16;
    localparam int RUN_W     = 15;
    localparam int EPOCH_W   = 8;

    localparam logic [HCNT_W-1:0] HCNT_MAX = '1;
    localparam logic [HCNT_W-1:0] RUN_MAX  = 16'd32767;

    typedef enum logic [1:0] {
        OUT_SKIP  = 2'd0,
        OUT_SHORT = 2'd1,
        OUT_COMP  = 2'd2
    } outcome_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD,
        ST_SCAN_START,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: src/kcub_hist.sv
// Level histogram memory with an epoch tag on each entry and a registered read port.
`default_nettype none

module kcub_hist #(
    parameter int DEPTH  = kcub_pkg::MAX_CORE_DEF + 1,
    parameter int ADDR_W = $clog2(kcub_pkg::MAX_CORE_DEF + 1)
) (
    input  wire logic                         aclk,
    input  wire logic [ADDR_W-1:0]            rd_addr,
    input  wire logic                         wr_en,
    input  wire logic [ADDR_W-1:0]            wr_addr,
    input  wire logic [kcub_pkg::EPOCH_W-1:0] wr_tag,
    input  wire logic [kcub_pkg::HCNT_W-1:0]  wr_count,
    input  wire logic [kcub_pkg::EPOCH_W-1:0] epoch,
    output logic      [kcub_pkg::HCNT_W-1:0]  rd_count
);

    localparam int HW = kcub_pkg::HCNT_W;
    localparam int TW = kcub_pkg::EPOCH_W;

    logic [TW+HW-1:0] mem [DEPTH];
    logic [TW+HW-1:0] rd_q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_tag, wr_count};
        end
        rd_q_reg <= mem[rd_addr];
    end

    // An entry written under an older epoch belongs to an earlier vertex and reads as zero.
    assign rd_count = (rd_q_reg[TW+HW-1:HW] == epoch) ? rd_q_reg[HW-1:0] : '0;

endmodule

`default_nettype wire

// File: src/kcub_step.sv
// Shared saturating adder with a threshold compare, used for counting and for the scan.
`default_nettype none

module kcub_step #(
    parameter int LVL_W = kcub_pkg::BOUND_W
) (
    input  wire logic [kcub_pkg::HCNT_W-1:0] a,
    input  wire logic [kcub_pkg::HCNT_W-1:0] b,
    input  wire logic [kcub_pkg::HCNT_W-1:0] limit,
    input  wire logic [LVL_W-1:0]            thresh,
    output logic      [kcub_pkg::HCNT_W-1:0] sum,
    output logic                             reached
);

    localparam int HW = kcub_pkg::HCNT_W;

    logic [HW:0] raw;

    assign raw     = {1'b0, a} + {1'b0, b};
    assign sum     = (raw > {1'b0, limit}) ? limit : raw[HW-1:0];
    assign reached = ({1'b0, sum} >= (HW+1)'(thresh));

endmodule

`default_nettype wire

// File: src/kcore_upper_bound_update.sv
// Top level: k-core upper bound update, sequencer around one histogram memory and one adder.
// Each neighbour transfer does the histogram read, then the saturating write-back, before the next.
// A run ends with the emit step for skipped or shortcut, or a scan-start step and a downward level scan
// for a computed update; the scan is bounded by the single histogram read port.
// aresetn is synchronous, active low; after reset a clearing pass over all MAX_CORE+1 entries runs,
// and the same pass repeats after every 255th vertex, with no input transfer taken meanwhile.
`default_nettype none

module kcore_upper_bound_update #(
    parameter int MAX_CORE = kcub_pkg::MAX_CORE_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [9:0]         s_vertex_bound,
    input  wire logic [9:0]         s_vertex_lower,
    input  wire logic signed [15:0] s_vertex_count,
    input  wire logic [11:0]        s_deposit,
    input  wire logic [9:0]         s_neighbor_bound,
    input  wire logic               s_neighbor_valid,
    input  wire logic               s_last_neighbor,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [9:0]              m_new_bound,
    output logic signed [15:0]      m_new_count,
    output logic [1:0]              m_outcome,
    output logic                    m_lowered
);

    localparam int DEPTH  = MAX_CORE + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BW     = kcub_pkg::BOUND_W;
    localparam int LVL_W  = (ADDR_W > BW) ? ADDR_W : BW;
    localparam int HW     = kcub_pkg::HCNT_W;
    localparam int RW     = kcub_pkg::RUN_W;
    localparam int TW     = kcub_pkg::EPOCH_W;
    localparam int DW     = kcub_pkg::DEPOSIT_W;

    localparam logic [LVL_W-1:0]  LVL_MAX   = LVL_W'(MAX_CORE);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAX_CORE);

    kcub_pkg::state_t   state_reg, state_next;
    logic               in_run_reg, in_run_next;
    logic [TW-1:0]      epoch_reg, epoch_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [BW-1:0]      bound_reg, bound_next;
    logic signed [15:0] count_reg, count_next;
    logic [DW-1:0]      deposit_reg, deposit_next;
    kcub_pkg::outcome_t outcome_reg, outcome_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic               valid_reg, valid_next;
    logic               last_reg, last_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic [RW-1:0]      run_reg, run_next;
    logic [BW-1:0]      nbound_reg, nbound_next;
    logic signed [15:0] ncount_reg, ncount_next;

    logic               m_valid_reg, m_valid_next;
    logic [BW-1:0]      m_new_bound_reg, m_new_bound_next;
    logic signed [15:0] m_new_count_reg, m_new_count_next;
    logic [1:0]         m_outcome_reg, m_outcome_next;
    logic               m_lowered_reg, m_lowered_next;

    logic               accept;
    logic [BW-1:0]      cur_bound;
    logic [LVL_W-1:0]   nb_min;
    logic [LVL_W-1:0]   lvl_in;
    kcub_pkg::outcome_t first_outcome;
    logic               scan_skip;
    logic [LVL_W-1:0]   start_lvl;
    logic [LVL_W-1:0]   dec_lvl;
    logic               out_free;

    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [TW-1:0]      wr_tag;
    logic [HW-1:0]      wr_count;
    logic [HW-1:0]      hist_count;

    logic [HW-1:0]      step_a, step_b, step_limit;
    logic [HW-1:0]      step_sum;
    logic               step_reached;

    assign s_ready = (state_reg == kcub_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;

    // The first transfer of a run brings the vertex fields; later ones use the held copy.
    assign cur_bound = in_run_reg ? bound_reg : s_vertex_bound;
    assign nb_min    = (s_neighbor_bound < cur_bound) ? LVL_W'(s_neighbor_bound)
                                                      : LVL_W'(cur_bound);
    assign lvl_in    = (nb_min > LVL_MAX) ? LVL_MAX : nb_min;

    always_comb begin
        if (s_vertex_lower == s_vertex_bound
                || s_vertex_count >= $signed({6'd0, s_vertex_bound})) begin
            first_outcome = kcub_pkg::OUT_SKIP;
        end else if ({1'b0, s_vertex_lower} + 11'd1 == {1'b0, s_vertex_bound}) begin
            first_outcome = kcub_pkg::OUT_SHORT;
        end else begin
            first_outcome = kcub_pkg::OUT_COMP;
        end
    end

    assign scan_skip = (DW'(bound_reg) <= deposit_reg);
    assign start_lvl = LVL_W'(bound_reg - deposit_reg[BW-1:0]);
    assign dec_lvl   = level_reg - LVL_W'(1);
    assign out_free  = !m_valid_reg || m_ready;

    kcub_hist #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_hist (
        .aclk     (aclk),
        .rd_addr  (rd_addr),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_tag   (wr_tag),
        .wr_count (wr_count),
        .epoch    (epoch_reg),
        .rd_count (hist_count)
    );

    kcub_step #(
        .LVL_W (LVL_W)
    ) u_step (
        .a       (step_a),
        .b       (step_b),
        .limit   (step_limit),
        .thresh  (level_reg),
        .sum     (step_sum),
        .reached (step_reached)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            kcub_pkg::ST_CLEAR: begin
                if (clr_addr_reg == ADDR_LAST) begin
                    state_next = kcub_pkg::ST_IDLE;
                end
            end
            kcub_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = kcub_pkg::ST_UPD;
                end
            end
            kcub_pkg::ST_UPD: begin
                if (!last_reg) begin
                    state_next = kcub_pkg::ST_IDLE;
                end else if (outcome_reg == kcub_pkg::OUT_COMP) begin
                    state_next = kcub_pkg::ST_SCAN_START;
                end else begin
                    state_next = kcub_pkg::ST_EMIT;
                end
            end
            kcub_pkg::ST_SCAN_START: begin
                state_next = scan_skip ? kcub_pkg::ST_EMIT : kcub_pkg::ST_SCAN;
            end
            kcub_pkg::ST_SCAN: begin
                if (step_reached || level_reg == LVL_W'(1)) begin
                    state_next = kcub_pkg::ST_EMIT;
                end
            end
            kcub_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = (epoch_reg == '1) ? kcub_pkg::ST_CLEAR : kcub_pkg::ST_IDLE;
                end
            end
            default: state_next = kcub_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        in_run_next      = in_run_reg;
        epoch_next       = epoch_reg;
        clr_addr_next    = clr_addr_reg;
        bound_next       = bound_reg;
        count_next       = count_reg;
        deposit_next     = deposit_reg;
        outcome_next     = outcome_reg;
        lvl_next         = lvl_reg;
        valid_next       = valid_reg;
        last_next        = last_reg;
        level_next       = level_reg;
        run_next         = run_reg;
        nbound_next      = nbound_reg;
        ncount_next      = ncount_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_new_bound_next = m_new_bound_reg;
        m_new_count_next = m_new_count_reg;
        m_outcome_next   = m_outcome_reg;
        m_lowered_next   = m_lowered_reg;

        rd_addr    = lvl_in[ADDR_W-1:0];
        wr_en      = 1'b0;
        wr_addr    = lvl_reg[ADDR_W-1:0];
        wr_tag     = epoch_reg;
        wr_count   = step_sum;
        step_a     = hist_count;
        step_b     = HW'(1);
        step_limit = kcub_pkg::HCNT_MAX;

        case (state_reg)
            kcub_pkg::ST_CLEAR: begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_tag        = '0;
                wr_count      = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_LAST) begin
                    clr_addr_next = '0;
                    epoch_next    = '0;
                end
            end
            kcub_pkg::ST_IDLE: begin
                if (accept) begin
                    lvl_next    = lvl_in;
                    valid_next  = s_neighbor_valid;
                    last_next   = s_last_neighbor;
                    in_run_next = !s_last_neighbor;
                    if (!in_run_reg) begin
                        bound_next   = s_vertex_bound;
                        count_next   = s_vertex_count;
                        deposit_next = s_deposit;
                        outcome_next = first_outcome;
                        epoch_next   = epoch_reg + TW'(1);
                    end
                end
            end
            kcub_pkg::ST_UPD: begin
                wr_en = valid_reg;
                if (last_reg) begin
                    nbound_next = (outcome_reg == kcub_pkg::OUT_SHORT)
                                ? bound_reg - BW'(1) : bound_reg;
                    ncount_next = count_reg;
                end
            end
            kcub_pkg::ST_SCAN_START: begin
                if (scan_skip) begin
                    nbound_next = bound_reg;
                    ncount_next = $signed(16'(deposit_reg));
                end else begin
                    level_next = start_lvl;
                    run_next   = RW'(deposit_reg);
                    rd_addr    = (start_lvl <= LVL_MAX) ? start_lvl[ADDR_W-1:0] : '0;
                end
            end
            kcub_pkg::ST_SCAN: begin
                // Levels above the histogram depth hold nothing and add zero.
                step_a      = HW'(run_reg);
                step_b      = (level_reg <= LVL_MAX) ? hist_count : '0;
                step_limit  = kcub_pkg::RUN_MAX;
                run_next    = step_sum[RW-1:0];
                ncount_next = $signed(step_sum);
                nbound_next = step_reached ? level_reg[BW-1:0] : bound_reg;
                level_next  = dec_lvl;
                rd_addr     = (dec_lvl <= LVL_MAX) ? dec_lvl[ADDR_W-1:0] : '0;
            end
            kcub_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_new_bound_next = nbound_reg;
                    m_new_count_next = ncount_reg;
                    m_outcome_next   = outcome_reg;
                    m_lowered_next   = (nbound_reg < bound_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= kcub_pkg::ST_CLEAR;
            in_run_reg   <= 1'b0;
            epoch_reg    <= '0;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_run_reg   <= in_run_next;
            epoch_reg    <= epoch_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bound_reg       <= bound_next;
        count_reg       <= count_next;
        deposit_reg     <= deposit_next;
        outcome_reg     <= outcome_next;
        lvl_reg         <= lvl_next;
        valid_reg       <= valid_next;
        last_reg        <= last_next;
        level_reg       <= level_next;
        run_reg         <= run_next;
        nbound_reg      <= nbound_next;
        ncount_reg      <= ncount_next;
        m_new_bound_reg <= m_new_bound_next;
        m_new_count_reg <= m_new_count_next;
        m_outcome_reg   <= m_outcome_next;
        m_lowered_reg   <= m_lowered_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_new_bound = m_new_bound_reg;
    assign m_new_count = m_new_count_reg;
    assign m_outcome   = m_outcome_reg;
    assign m_lowered   = m_lowered_reg;

    // Every input transfer is followed by its write-back cycle before the next one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input transfer taken during histogram write-back");

    // A result appears only after the sequencer has reached the emit step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == kcub_pkg::ST_EMIT))
        else $error("result raised outside the emit step");

    // The scan stops at level one and never visits level zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kcub_pkg::ST_SCAN) |-> (level_reg != '0))
        else $error("histogram scan reached level zero");

    // A skipped vertex keeps its bound.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_lowered) |-> (m_outcome != kcub_pkg::OUT_SKIP))
        else $error("skipped vertex reported a lowered bound");

    // The clearing pass runs only between vertices.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kcub_pkg::ST_CLEAR) |-> !in_run_reg)
        else $error("histogram clearing started inside a vertex run");

endmodule

`default_nettype wire

// File: bench/kcore_upper_bound_update_tb.sv
// Self-checking testbench for the k-core upper bound update block.
`timescale 1ns / 100ps

module kcore_upper_bound_update_tb;

    localparam int MAX_CORE     = kcub_pkg::MAX_CORE_DEF;
    localparam int LIMIT_CYCLES = 20_000_000;
    localparam int TAIL_CYCLES  = 1600;
    localparam int HOLD_CYCLES  = 400;
    localparam int NO_NEIGHBOUR = -1;

    typedef struct {
        logic [9:0]         vbound;
        logic [9:0]         vlower;
        logic signed [15:0] vcount;
        logic [11:0]        dep;
        logic [9:0]         nbound;
        logic               nvalid;
        logic               last;
    } nbr_item_t;

    typedef struct {
        logic [9:0]         bound;
        logic signed [15:0] count;
        kcub_pkg::outcome_t outcome;
        logic               lowered;
    } bound_update_t;

    // Mirrors the block: latches the vertex on the opening transfer, builds the level
    // histogram and queues the bound update due when the run closes.
    class ub_scoreboard;
        logic [15:0]        level_hist [0:MAX_CORE];
        logic [9:0]         lat_bound;
        logic [9:0]         lat_lower;
        logic signed [15:0] lat_count;
        logic [11:0]        lat_deposit;
        kcub_pkg::outcome_t lat_outcome;
        bit                 in_run;
        bound_update_t      pending_q[$];
        int                 mismatches;
        int                 updates_seen;
        int                 outcome_tally[3];
        int                 lowered_tally;

        function new();
            foreach (level_hist[i]) level_hist[i] = '0;
            in_run        = 0;
            mismatches    = 0;
            updates_seen  = 0;
            lowered_tally = 0;
            foreach (outcome_tally[i]) outcome_tally[i] = 0;
        endfunction

        function void absorb_item(nbr_item_t it);
            int            lvl;
            int            run;
            int            nb_new;
            bound_update_t upd;
            if (!in_run) begin
                lat_bound   = it.vbound;
                lat_lower   = it.vlower;
                lat_count   = it.vcount;
                lat_deposit = it.dep;
                foreach (level_hist[i]) level_hist[i] = '0;
                if (lat_lower == lat_bound || int'(lat_count) >= int'(lat_bound))
                    lat_outcome = kcub_pkg::OUT_SKIP;
                else if (int'(lat_lower) + 1 == int'(lat_bound))
                    lat_outcome = kcub_pkg::OUT_SHORT;
                else
                    lat_outcome = kcub_pkg::OUT_COMP;
            end
            if (it.nvalid) begin
                lvl = (it.nbound < lat_bound) ? int'(it.nbound) : int'(lat_bound);
                if (lvl > MAX_CORE) lvl = MAX_CORE;
                if (level_hist[lvl] != 16'hFFFF) level_hist[lvl] = level_hist[lvl] + 1'b1;
            end
            if (!it.last) begin
                in_run = 1;
                return;
            end
            in_run = 0;
            nb_new = int'(lat_bound);
            upd.count = lat_count;
            if (lat_outcome == kcub_pkg::OUT_SHORT) begin
                nb_new = int'(lat_bound) - 1;
            end else if (lat_outcome == kcub_pkg::OUT_COMP) begin
                // The running count starts from the deposit; levels beyond the
                // histogram add nothing but are still visited.
                run = int'(lat_deposit);
                for (int i = int'(lat_bound) - int'(lat_deposit); i > 0; i--) begin
                    if (i <= MAX_CORE) begin
                        run += int'(level_hist[i]);
                        if (run > 32767) run = 32767;
                    end
                    if (run >= i) begin
                        nb_new = i;
                        break;
                    end
                end
                upd.count = 16'(run);
            end
            upd.bound   = 10'(nb_new);
            upd.outcome = lat_outcome;
            upd.lowered = (nb_new < int'(lat_bound));
            pending_q.insert(pending_q.size(), upd);
        endfunction

        function void check_update(bound_update_t got);
            bound_update_t want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected update: bound %0d count %0d outcome %0d lowered %0d",
                             got.bound, got.count, got.outcome, got.lowered);
                return;
            end
            want = pending_q.pop_front();
            updates_seen++;
            outcome_tally[int'(want.outcome)]++;
            if (want.lowered) lowered_tally++;
            if (got.bound !== want.bound || got.count !== want.count ||
                got.outcome !== want.outcome || got.lowered !== want.lowered) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch on update %0d (expected/actual):", updates_seen);
                    $display("  bound %0d/%0d count %0d/%0d outcome %0d/%0d lowered %0d/%0d",
                             want.bound, got.bound, want.count, got.count,
                             want.outcome, got.outcome, want.lowered, got.lowered);
                end
            end
        endfunction
    endclass

    logic               aclk             = 1'b0;
    logic               aresetn          = 1'b0;
    logic               s_valid          = 1'b0;
    logic               s_ready;
    logic [9:0]         s_vertex_bound   = '0;
    logic [9:0]         s_vertex_lower   = '0;
    logic signed [15:0] s_vertex_count   = '0;
    logic [11:0]        s_deposit        = '0;
    logic [9:0]         s_neighbor_bound = '0;
    logic               s_neighbor_valid = 1'b0;
    logic               s_last_neighbor  = 1'b0;
    logic               m_valid;
    logic               m_ready          = 1'b0;
    logic [9:0]         m_new_bound;
    logic signed [15:0] m_new_count;
    logic [1:0]         m_outcome;
    logic               m_lowered;

    ub_scoreboard sb;
    int           src_idle_pct  = 13;
    int           snk_idle_pct  = 70;
    int           hold_request  = 0;
    int           hold_left     = 0;
    int           items_sent    = 0;
    int           cycle_count   = 0;

    kcore_upper_bound_update u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_vertex_bound   (s_vertex_bound),
        .s_vertex_lower   (s_vertex_lower),
        .s_vertex_count   (s_vertex_count),
        .s_deposit        (s_deposit),
        .s_neighbor_bound (s_neighbor_bound),
        .s_neighbor_valid (s_neighbor_valid),
        .s_last_neighbor  (s_last_neighbor),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_new_bound      (m_new_bound),
        .m_new_count      (m_new_count),
        .m_outcome        (m_outcome),
        .m_lowered        (m_lowered)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: checks every transfer and applies random or long back-pressure.
    always @(posedge aclk) begin : result_side
        bound_update_t got;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.bound   = m_new_bound;
                got.count   = m_new_count;
                got.outcome = kcub_pkg::outcome_t'(m_outcome);
                got.lowered = m_lowered;
                sb.check_update(got);
            end
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    task automatic send_item(input nbr_item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_vertex_bound   <= it.vbound;
        s_vertex_lower   <= it.vlower;
        s_vertex_count   <= it.vcount;
        s_deposit        <= it.dep;
        s_neighbor_bound <= it.nbound;
        s_neighbor_valid <= it.nvalid;
        s_last_neighbor  <= it.last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.absorb_item(it);
        items_sent++;
    endtask

    // Sends one vertex; vertex fields after the opening transfer are random, since the
    // block must ignore them.
    task automatic send_run(input int vb, input int vl, input int vc, input int dep,
                            input int nbrs[$]);
        nbr_item_t it;
        for (int k = 0; k < nbrs.size(); k++) begin
            if (k == 0) begin
                it.vbound = 10'(vb);
                it.vlower = 10'(vl);
                it.vcount = 16'(vc);
                it.dep    = 12'(dep);
            end else begin
                it.vbound = 10'($urandom);
                it.vlower = 10'($urandom);
                it.vcount = 16'($urandom);
                it.dep    = 12'($urandom);
            end
            it.nvalid = (nbrs[k] != NO_NEIGHBOUR);
            it.nbound = it.nvalid ? 10'(nbrs[k]) : 10'($urandom);
            it.last   = (k == nbrs.size() - 1);
            send_item(it);
        end
    endtask

    task automatic send_random_vertex();
        int vb;
        int vl;
        int vc;
        int dep;
        int len;
        int hi;
        int pick;
        int nbrs[$];
        pick = $urandom_range(99);
        if (pick < 85)      vb = $urandom_range(48);
        else if (pick < 95) vb = $urandom_range(512);
        else                vb = $urandom_range(1023);
        pick = $urandom_range(99);
        if (pick < 25)                vl = vb;
        else if (pick < 50 && vb > 0) vl = vb - 1;
        else if (pick < 90)           vl = $urandom_range(vb);
        else                          vl = $urandom_range(1023);
        pick = $urandom_range(99);
        if (pick < 20)      vc = vb + $urandom_range(32767 - vb);
        else if (pick < 50) vc = int'($urandom_range(65535)) - 32768;
        else                vc = int'($urandom_range(vb + 100)) - 100;
        pick = $urandom_range(99);
        if (pick < 55)      dep = $urandom_range(3);
        else if (pick < 85) dep = $urandom_range(vb + 2);
        else                dep = $urandom_range(4095);
        pick = $urandom_range(99);
        if (pick < 70)      len = $urandom_range(6, 1);
        else if (pick < 95) len = $urandom_range(40, 7);
        else                len = $urandom_range(300, 41);
        hi = (vb + 3 > 1023) ? 1023 : vb + 3;
        repeat (len) begin
            pick = $urandom_range(99);
            if (pick < 6)       nbrs.insert(nbrs.size(), NO_NEIGHBOUR);
            else if (pick < 88) nbrs.insert(nbrs.size(), int'($urandom_range(hi)));
            else                nbrs.insert(nbrs.size(), int'($urandom_range(1023)));
        end
        send_run(vb, vl, vc, dep, nbrs);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
    endtask

    task automatic run_random_phase(input int n_items, input int src_pct, input int snk_pct,
                                    input bit with_hold);
        int start_count;
        bit held;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        start_count  = items_sent;
        held         = 0;
        while (items_sent - start_count < n_items) begin
            // Starve the result side while transfers keep coming so the block backs up.
            if (with_hold && !held && items_sent - start_count >= n_items / 2) begin
                hold_request = HOLD_CYCLES;
                held         = 1;
            end
            send_random_vertex();
        end
        wait_drained();
    endtask

    initial begin
        int nq[$];
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed vertices: each outcome, single-transfer runs, ignored vertex fields on
        // later transfers, no neighbours, deposit beyond the bound, a zero bound with a
        // negative count, bounds beyond the histogram and the field extremes.
        nq = '{3};                   send_run(7, 7, 0, 0, nq);
        nq = '{1};                   send_run(5, 0, 5, 0, nq);
        nq = '{4, 12};               send_run(10, 9, -3, 0, nq);
        nq = '{6, 6, 2, 9, 0};       send_run(6, 0, 0, 1, nq);
        nq = '{NO_NEIGHBOUR};        send_run(4, 0, -1, 0, nq);
        nq = '{2};                   send_run(3, 0, -32768, 4095, nq);
        nq = '{0};                   send_run(0, 1023, -1, 0, nq);
        nq = '{1023, 600, 0, 513};   send_run(1023, 0, -32768, 0, nq);
        nq = '{1023};                send_run(1023, 1022, 1000, 4095, nq);
        nq = '{NO_NEIGHBOUR};        send_run(1023, 1023, 32767, 4095, nq);
        nq = '{2, 2};                send_run(2, 0, -1, 0, nq);
        wait_drained();

        run_random_phase(600, 13, 70, 1);
        run_random_phase(600, 70, 13, 0);
        run_random_phase(600, 0, 0, 1);

        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d items; %0d updates: %0d skip / %0d short / %0d comp / %0d lowered",
                 items_sent, sb.updates_seen, sb.outcome_tally[kcub_pkg::OUT_SKIP],
                 sb.outcome_tally[kcub_pkg::OUT_SHORT], sb.outcome_tally[kcub_pkg::OUT_COMP],
                 sb.lowered_tally);
        $display("Runs mixed idle patterns, bounds past the histogram and long output stalls.");
        if (sb.pending_q.size() != 0)
            $display("%0d expected updates never arrived", sb.pending_q.size());
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
